// ===== sv/spectrum_bin_min_max_mean_tracker_assert.svh =====
// assertion macros for the spectrum bin tracker
// used by the top level; expects clk and rst_n in scope
`ifndef SPECTRUM_BIN_MIN_MAX_MEAN_TRACKER_ASSERT_SVH
`define SPECTRUM_BIN_MIN_MAX_MEAN_TRACKER_ASSERT_SVH

// antecedent holds, consequent holds in the same cycle
`define SBT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds, consequent holds in the following cycle
`define SBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sbt_pkg.sv =====
// shared constants, command and result types for the spectrum bin tracker
// no dependencies
package sbt_pkg;

  localparam int MAX_BLOCKS  = 8;
  localparam int NUM_BINS    = 256;
  localparam int STORE_DEPTH = MAX_BLOCKS * NUM_BINS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int BLK_W       = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  localparam int BLOCK_IN_W = 3;
  localparam int BIN_IN_W   = 8;
  localparam int AMP_W      = 8;
  localparam int MEAN_W     = 16;
  localparam int COUNT_W    = 16;
  localparam int DIVISOR_W  = COUNT_W + 1;
  localparam int STEP_W     = $clog2(MEAN_W);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int ENTRY_W = 1 + 2 * AMP_W + MEAN_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    CMD_SAMPLE,
    CMD_SKIP,
    CMD_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [ADDR_W-1:0]  addr;
    logic [BLK_W-1:0]   blk;
    logic [AMP_W-1:0]   amp;
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic [AMP_W-1:0]   min_level;
    logic [AMP_W-1:0]   max_level;
    logic [MEAN_W-1:0]  mean_level;
    logic [COUNT_W-1:0] frames_seen;
  } res_t;

  typedef struct packed {
    logic seen;
    logic [AMP_W-1:0]  min_v;
    logic [AMP_W-1:0]  max_v;
    logic [MEAN_W-1:0] mean_v;
  } entry_t;

  typedef struct packed {
    logic init_busy;
  } back_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CLEAR,
    BK_FIN,
    BK_READ,
    BK_DIV,
    BK_WRITE
  } back_state_t;

endpackage

// ===== sv/sbt_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module sbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/sbt_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
// depends on sbt_pkg
module sbt_div import sbt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [MEAN_W-1:0]    dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  output logic                 done,
  output logic [MEAN_W-1:0]    quotient
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic [DIVISOR_W-1:0] rem_r, rem_nxt;
  logic [MEAN_W-1:0]    dq_r, dq_nxt;
  logic [DIVISOR_W-1:0] dvs_r, dvs_nxt;

  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   trial_sub;
  logic                 ge;

  // shift in the next dividend bit and try a subtract
  assign trial     = {rem_r, dq_r[MEAN_W-1]};
  assign ge        = trial >= {1'b0, dvs_r};
  assign trial_sub = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      dq_nxt   = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = ge ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      dq_nxt   = {dq_r[MEAN_W-2:0], ge};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(MEAN_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    dq_r   <= dq_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

// ===== sv/sbt_front.sv =====
// front end: classifies incoming items into commands and queues them
// depends on sbt_pkg
module sbt_front import sbt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  hold,
  input  logic                  push,
  input  logic                  mode,
  input  logic [BLOCK_IN_W-1:0] rf_block,
  input  logic [BIN_IN_W-1:0]   bin_index,
  input  logic [AMP_W-1:0]      amplitude,
  input  logic                  last_bin,
  output logic                  full,
  output logic                  q_valid,
  output cmd_t                  q_cmd,
  input  logic                  q_pop
);

  cmd_t              q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  cmd_t in_cmd;
  logic accept;
  logic in_range;

  assign in_range = (int'(rf_block) < MAX_BLOCKS) && (int'(bin_index) < NUM_BINS);

  always_comb begin
    in_cmd.addr = ADDR_W'(int'(rf_block) * NUM_BINS + int'(bin_index));
    in_cmd.blk  = BLK_W'(rf_block);
    in_cmd.amp  = amplitude;
    in_cmd.last = last_bin;
    if (mode) begin
      in_cmd.kind = CMD_CLEAR;
    end else if (in_range) begin
      in_cmd.kind = CMD_SAMPLE;
    end else begin
      in_cmd.kind = CMD_SKIP;
    end
  end

  assign full    = hold || (cnt_r == QCNT_W'(QDEPTH));
  assign accept  = push && !full;
  assign q_valid = cnt_r != '0;
  assign q_cmd   = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (accept) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (accept && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!accept && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (accept) begin
      q_mem_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

// ===== sv/sbt_back.sv =====
// back end: executes queued commands against the bin store and frame counters
// depends on sbt_pkg, sbt_ram and sbt_div
module sbt_back import sbt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  input  logic       out_pop,
  output logic       out_empty,
  output res_t       res,
  output back_stat_t stat
);

  back_state_t       state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [ADDR_W-1:0] sweep_r, sweep_nxt;
  logic              rpt_r, rpt_nxt;
  logic              init_r, init_nxt;
  logic [COUNT_W-1:0] frame_cnt_r [MAX_BLOCKS];
  logic [AMP_W-1:0]  min_r, min_nxt;
  logic [AMP_W-1:0]  max_r, max_nxt;
  logic [MEAN_W-1:0] mean_r, mean_nxt;
  logic              neg_r, neg_nxt;
  res_t              res_r, res_nxt;
  logic              res_valid_r, res_valid_nxt;

  logic               slot_free;
  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  entry_t             rd;
  entry_t             wr_entry;
  logic               div_start, div_done;
  logic [MEAN_W-1:0]  div_dividend, div_quot;
  logic [DIVISOR_W-1:0] div_divisor;
  logic               res_load;
  logic               cnt_bump;
  logic [COUNT_W-1:0] cnt_cur, cnt_new;
  logic [MEAN_W-1:0]  target;

  assign slot_free = !res_valid_r || out_pop;
  assign rd        = entry_t'(ram_rdata);
  assign cnt_cur   = frame_cnt_r[cmd_r.blk];
  assign cnt_new   = (cmd_r.last && cnt_cur != COUNT_MAX) ? cnt_cur + 1'b1 : cnt_cur;
  assign target    = {cmd_r.amp, {(MEAN_W - AMP_W){1'b0}}};

  always_comb begin
    wr_entry.seen   = 1'b1;
    wr_entry.min_v  = min_r;
    wr_entry.max_v  = max_r;
    wr_entry.mean_v = mean_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_pop) begin
          case (q_cmd.kind)
            CMD_CLEAR:  state_nxt = BK_CLEAR;
            CMD_SAMPLE: state_nxt = BK_READ;
            default:    state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_CLEAR: begin
        if (sweep_r == ADDR_W'(STORE_DEPTH - 1)) begin
          state_nxt = BK_FIN;
        end
      end
      BK_FIN: begin
        if (!rpt_r || slot_free) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_READ: begin
        state_nxt = rd.seen ? BK_DIV : BK_WRITE;
      end
      BK_DIV: begin
        if (div_done) begin
          state_nxt = BK_WRITE;
        end
      end
      BK_WRITE: begin
        if (slot_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop     = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = cmd_r.addr;
    ram_wdata = ENTRY_W'(wr_entry);
    div_start = 1'b0;
    res_load  = 1'b0;
    cnt_bump  = 1'b0;
    case (state_r)
      BK_IDLE: begin
        // a skipped item answers at once, so it needs the result slot now
        q_pop  = q_valid && (q_cmd.kind != CMD_SKIP || slot_free);
        ram_re = q_pop && q_cmd.kind == CMD_SAMPLE;
        res_load = q_pop && q_cmd.kind == CMD_SKIP;
      end
      BK_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_r;
        ram_wdata = '0;
      end
      BK_FIN: begin
        res_load = rpt_r && slot_free;
      end
      BK_READ: begin
        div_start = rd.seen;
      end
      BK_WRITE: begin
        ram_we   = slot_free;
        res_load = slot_free;
        cnt_bump = slot_free;
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    cmd_nxt       = q_pop ? q_cmd : cmd_r;
    sweep_nxt     = sweep_r;
    rpt_nxt       = rpt_r;
    init_nxt      = init_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    mean_nxt      = mean_r;
    neg_nxt       = neg_r;
    div_dividend  = target - rd.mean_v;
    div_divisor   = DIVISOR_W'(cnt_cur) + DIVISOR_W'(1);
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r && !out_pop;

    if (state_r == BK_IDLE && q_pop && q_cmd.kind == CMD_CLEAR) begin
      sweep_nxt = '0;
      rpt_nxt   = 1'b1;
    end
    if (state_r == BK_CLEAR) begin
      sweep_nxt = sweep_r + 1'b1;
    end
    if (state_r == BK_FIN) begin
      init_nxt = 1'b0;
    end

    if (state_r == BK_READ) begin
      if (!rd.seen) begin
        min_nxt  = cmd_r.amp;
        max_nxt  = cmd_r.amp;
        mean_nxt = target;
      end else begin
        min_nxt  = (cmd_r.amp < rd.min_v) ? cmd_r.amp : rd.min_v;
        max_nxt  = (cmd_r.amp > rd.max_v) ? cmd_r.amp : rd.max_v;
        mean_nxt = rd.mean_v;
        neg_nxt  = target < rd.mean_v;
        if (target < rd.mean_v) begin
          div_dividend = rd.mean_v - target;
        end
      end
    end
    if (state_r == BK_DIV && div_done) begin
      mean_nxt = neg_r ? mean_r - div_quot : mean_r + div_quot;
    end

    if (res_load) begin
      res_valid_nxt = 1'b1;
      if (state_r == BK_WRITE) begin
        res_nxt.min_level   = min_r;
        res_nxt.max_level   = max_r;
        res_nxt.mean_level  = mean_r;
        res_nxt.frames_seen = cnt_new;
      end else begin
        res_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      sweep_r     <= '0;
      rpt_r       <= 1'b0;
      init_r      <= 1'b1;
      res_valid_r <= 1'b0;
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        frame_cnt_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      rpt_r       <= rpt_nxt;
      init_r      <= init_nxt;
      res_valid_r <= res_valid_nxt;
      if (state_r == BK_IDLE && q_pop && q_cmd.kind == CMD_CLEAR) begin
        for (int i = 0; i < MAX_BLOCKS; i++) begin
          frame_cnt_r[i] <= '0;
        end
      end else if (cnt_bump) begin
        frame_cnt_r[cmd_r.blk] <= cnt_new;
      end
    end
    cmd_r  <= cmd_nxt;
    min_r  <= min_nxt;
    max_r  <= max_nxt;
    mean_r <= mean_nxt;
    neg_r  <= neg_nxt;
    res_r  <= res_nxt;
  end

  sbt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (q_cmd.addr),
    .rdata (ram_rdata)
  );

  sbt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign out_empty      = !res_valid_r;
  assign res            = res_r;
  assign stat.init_busy = init_r;

endmodule

// ===== sv/spectrum_bin_min_max_mean_tracker.sv =====
// a repeated bin shows its result after the queue, the store read and the 16-step radix-2
// divider; a first sample after a clear skips the divider
// one item is handled at a time; the queue holds up to two waiting items; a clear item
// sweeps the 2048-entry bin store and then answers with an all-zero result
// reset: rst_n synchronous; afterwards the store is swept and full stays high until the sweep ends
module spectrum_bin_min_max_mean_tracker import sbt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic                  in_mode,
  input  logic [BLOCK_IN_W-1:0] in_rf_block,
  input  logic [BIN_IN_W-1:0]   in_bin_index,
  input  logic [AMP_W-1:0]      in_amplitude,
  input  logic                  in_last_bin,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [AMP_W-1:0]      out_min_level,
  output logic [AMP_W-1:0]      out_max_level,
  output logic [MEAN_W-1:0]     out_mean_level,
  output logic [COUNT_W-1:0]    out_frames_seen
);

`include "spectrum_bin_min_max_mean_tracker_assert.svh"

  logic       q_valid;
  cmd_t       q_cmd;
  logic       q_pop;
  res_t       res;
  back_stat_t stat;

  sbt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .hold      (stat.init_busy),
    .push      (in_push),
    .mode      (in_mode),
    .rf_block  (in_rf_block),
    .bin_index (in_bin_index),
    .amplitude (in_amplitude),
    .last_bin  (in_last_bin),
    .full      (in_full),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  sbt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .res       (res),
    .stat      (stat)
  );

  assign out_min_level   = res.min_level;
  assign out_max_level   = res.max_level;
  assign out_mean_level  = res.mean_level;
  assign out_frames_seen = res.frames_seen;

  `SBT_ASSERT_SAME(a_init_blocks_input, stat.init_busy, in_full, "item taken during store sweep")
  `SBT_ASSERT_SAME(a_pop_needs_item, q_pop, q_valid, "back end popped an empty queue")
  `SBT_ASSERT_NEXT(a_transfer_queued, in_push && !in_full, q_valid, "transfer not queued")

endmodule
